// ===== rtl/core/event_hough_circle_window_macros.svh =====
// Assertion macros shared by the event Hough circle window RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef EVENT_HOUGH_CIRCLE_WINDOW_MACROS_SVH
`define EVENT_HOUGH_CIRCLE_WINDOW_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define EHCW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent holds whenever the antecedent holds.
`define EHCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ehcw_pkg.sv =====
// Shared constants and controller/datapath command types for the
// event Hough circle window. No dependencies.
package ehcw_pkg;

    localparam int NUM_RADII   = 24;
    localparam int IMG_W       = 128;
    localparam int IMG_H       = 128;
    localparam int QUEUE_DEPTH = 2048;

    localparam int X_W       = $clog2(IMG_W);
    localparam int Y_W       = $clog2(IMG_H);
    localparam int R_IDX_W   = $clog2(NUM_RADII);
    localparam int MEM_DEPTH = NUM_RADII * IMG_H * IMG_W;
    localparam int MEM_AW    = R_IDX_W + Y_W + X_W;
    localparam int Q_AW      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = Q_AW + 1;
    localparam int EV_W      = X_W + Y_W;

    localparam int VOTE_W   = 13;
    localparam int VOTE_MAX = 8191;
    localparam int MINR_W   = 7;
    localparam int WLEN_W   = 11;
    localparam int RAD_W    = 8;
    localparam int RADO_W   = 7;
    localparam int RADO_MAX = 127;
    localparam int SQ_W     = 2 * RAD_W;
    localparam int BIT_W    = $clog2(RAD_W);
    localparam int ROW_W    = Y_W + 3;
    localparam int MINR_RST = 8;
    localparam int WLEN_RST = 2000;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 11;
    localparam logic [CFG_AW-1:0] CFG_MIN_RADIUS    = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_LENGTH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load_event;
        logic queue_rd;
        logic push;
        logic pop_load;
        logic pop_done;
        logic rad_init;
        logic rad_next;
        logic col_init;
        logic sqrt_step;
        logic cell_read;
        logic cell_write;
        logic cell_next;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic need_pop;
        logic rad_done;
        logic col_done;
        logic sqrt_last;
        logic row_ok;
        logic cell_last;
        logic add_pass;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== rtl/core/ehcw_in_if.sv =====
// Event input channel: valid/ready handshake with one pixel event.
// Depends on ehcw_pkg.
interface ehcw_in_if;
    logic                     valid;
    logic                     ready;
    logic [ehcw_pkg::X_W-1:0] event_x;
    logic [ehcw_pkg::Y_W-1:0] event_y;

    modport source (output valid, output event_x, output event_y, input ready);
    modport sink (input valid, input event_x, input event_y, output ready);
endinterface

// ===== rtl/core/ehcw_out_if.sv =====
// Result output channel: valid/ready handshake with the best circle cell.
// Depends on ehcw_pkg.
interface ehcw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [ehcw_pkg::X_W-1:0]    center_x;
    logic [ehcw_pkg::Y_W-1:0]    center_y;
    logic [ehcw_pkg::RADO_W-1:0] radius;
    logic [ehcw_pkg::VOTE_W-1:0] votes;

    modport source (output valid, output found, output center_x, output center_y,
                    output radius, output votes, input ready);
    modport sink (input valid, input found, input center_x, input center_y,
                  input radius, input votes, output ready);
endinterface

// ===== rtl/core/ehcw_ram.sv =====
// Generic single-port RAM with one write and a registered read.
// No dependencies.
module ehcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// ===== rtl/core/ehcw_ctrl.sv =====
// Controller state machine sequencing the clear sweep, withdrawal passes,
// the vote pass and result hand-off. Depends on ehcw_pkg.
module ehcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ehcw_pkg::t_dp_sts i_sts,
    output ehcw_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_POP_LOAD = 4'd3;
    localparam logic [3:0] S_RAD      = 4'd4;
    localparam logic [3:0] S_COL      = 4'd5;
    localparam logic [3:0] S_SQRT     = 4'd6;
    localparam logic [3:0] S_CELL     = 4'd7;
    localparam logic [3:0] S_WRITE    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and per-state commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_event = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_pop) begin
                    o_cmd.queue_rd = 1'b1;
                    n_state        = S_POP_LOAD;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = S_RAD;
                end
            end
            S_POP_LOAD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_RAD;
            end
            S_RAD: begin
                if (i_sts.rad_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rad_init = 1'b1;
                    n_state        = S_COL;
                end
            end
            S_COL: begin
                if (i_sts.col_done) begin
                    o_cmd.rad_next = 1'b1;
                    n_state        = S_RAD;
                end else begin
                    o_cmd.col_init = 1'b1;
                    n_state        = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) n_state = S_CELL;
            end
            S_CELL: begin
                if (i_sts.row_ok) begin
                    o_cmd.cell_read = 1'b1;
                    n_state         = S_WRITE;
                end else begin
                    o_cmd.cell_next = 1'b1;
                    if (i_sts.cell_last) n_state = S_COL;
                end
            end
            S_WRITE: begin
                o_cmd.cell_write = 1'b1;
                o_cmd.cell_next  = 1'b1;
                n_state          = i_sts.cell_last ? S_COL : S_CELL;
            end
            S_DONE: begin
                if (i_sts.add_pass) begin
                    if (!i_sts.out_full) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.pop_done = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ehcw_datapath.sv =====
// Datapath: configuration, event queue, vote memory, circle geometry,
// square root unit, best-cell tracking and result register.
// Depends on ehcw_pkg, ehcw_ram, ehcw_out_if and the macros header.
`include "event_hough_circle_window_macros.svh"

module ehcw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ehcw_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [ehcw_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic [ehcw_pkg::X_W-1:0]      i_event_x,
    input  logic [ehcw_pkg::Y_W-1:0]      i_event_y,
    input  ehcw_pkg::t_dp_cmd             i_cmd,
    output ehcw_pkg::t_dp_sts             o_sts,
    ehcw_out_if.source                    o_res
);

    // Configuration.
    logic [ehcw_pkg::MINR_W-1:0]  r_min_radius;
    logic [ehcw_pkg::WLEN_W-1:0]  r_window_length;
    // Control counters.
    logic [ehcw_pkg::MEM_AW-1:0]  r_clr_addr;
    logic [ehcw_pkg::Q_AW-1:0]    r_q_head;
    logic [ehcw_pkg::CNT_W-1:0]   r_q_count;
    logic                         r_out_valid;
    // Event and pass cursor.
    logic [ehcw_pkg::X_W-1:0]     r_ev_x;
    logic [ehcw_pkg::Y_W-1:0]     r_ev_y;
    logic [ehcw_pkg::X_W-1:0]     r_cx;
    logic [ehcw_pkg::Y_W-1:0]     r_cy;
    logic                         r_add;
    logic [ehcw_pkg::R_IDX_W:0]   r_ridx;
    logic [ehcw_pkg::RAD_W-1:0]   r_rad;
    logic [ehcw_pkg::SQ_W-1:0]    r_rad_sq;
    logic [ehcw_pkg::X_W-1:0]     r_x;
    logic [ehcw_pkg::X_W-1:0]     r_xe;
    logic [ehcw_pkg::SQ_W-1:0]    r_sq;
    logic [ehcw_pkg::RAD_W-1:0]   r_root;
    logic [ehcw_pkg::BIT_W-1:0]   r_bit;
    logic [1:0]                   r_s;
    logic                         r_minus;
    // Best cell and result.
    logic [ehcw_pkg::VOTE_W-1:0]  r_best_votes;
    logic [ehcw_pkg::X_W-1:0]     r_best_x;
    logic [ehcw_pkg::Y_W-1:0]     r_best_y;
    logic [ehcw_pkg::RADO_W-1:0]  r_best_rad;
    logic                         r_o_found;
    logic [ehcw_pkg::X_W-1:0]     r_o_cx;
    logic [ehcw_pkg::Y_W-1:0]     r_o_cy;
    logic [ehcw_pkg::RADO_W-1:0]  r_o_rad;
    logic [ehcw_pkg::VOTE_W-1:0]  r_o_votes;

    logic [ehcw_pkg::RAD_W-1:0]        w_rad;
    logic signed [ehcw_pkg::RAD_W+1:0] w_lo;
    logic [ehcw_pkg::RAD_W+1:0]        w_hi;
    logic [ehcw_pkg::X_W-1:0]          w_dx_abs;
    logic [2*ehcw_pkg::X_W-1:0]        w_dx_sq;
    logic [ehcw_pkg::RAD_W-1:0]        w_trial;
    logic [ehcw_pkg::SQ_W-1:0]         w_trial_sq;
    logic signed [ehcw_pkg::ROW_W-1:0] w_ey;
    logic signed [ehcw_pkg::ROW_W-1:0] w_dy;
    logic signed [ehcw_pkg::ROW_W-1:0] w_row;
    logic                              w_row_ok;
    logic                              w_cell_last;
    logic [ehcw_pkg::VOTE_W-1:0]       w_rdata;
    logic [ehcw_pkg::VOTE_W-1:0]       w_new;
    logic                              w_mem_we;
    logic [ehcw_pkg::MEM_AW-1:0]       w_mem_addr;
    logic [ehcw_pkg::VOTE_W-1:0]       w_mem_wdata;
    logic [ehcw_pkg::Q_AW-1:0]         w_q_addr;
    logic [ehcw_pkg::EV_W-1:0]         w_q_rdata;

    // Circle geometry for the current radius, column and row step.
    assign w_rad      = ehcw_pkg::RAD_W'(r_min_radius) + ehcw_pkg::RAD_W'(r_ridx);
    assign w_lo       = $signed({3'b000, r_cx}) - $signed({2'b00, w_rad});
    assign w_hi       = {3'b000, r_cx} + {2'b00, w_rad};
    assign w_dx_abs   = (r_x >= r_cx) ? (r_x - r_cx) : (r_cx - r_x);
    assign w_dx_sq    = w_dx_abs * w_dx_abs;
    assign w_trial    = r_root | (ehcw_pkg::RAD_W'(1) << r_bit);
    assign w_trial_sq = w_trial * w_trial;
    assign w_ey       = $signed({3'b000, r_cy});
    assign w_dy       = $signed({2'b00, r_root});
    assign w_row      = w_ey + (r_minus ? -w_dy : w_dy)
                      + $signed(ehcw_pkg::ROW_W'(r_s)) - $signed(ehcw_pkg::ROW_W'(1));
    assign w_row_ok   = !w_row[ehcw_pkg::ROW_W-1] && (w_row <= ehcw_pkg::IMG_H - 1);
    assign w_cell_last = (r_s == 2'd2) && r_minus;

    // Saturating read-modify-write value.
    always_comb begin
        if (r_add) begin
            w_new = (w_rdata == ehcw_pkg::VOTE_W'(ehcw_pkg::VOTE_MAX)) ? w_rdata
                                                                      : w_rdata + 1'b1;
        end else begin
            w_new = (w_rdata == '0) ? w_rdata : w_rdata - 1'b1;
        end
    end

    // Vote memory port: clear sweep or cell access.
    assign w_mem_we    = i_cmd.clr_step || i_cmd.cell_write;
    assign w_mem_wdata = i_cmd.clr_step ? '0 : w_new;
    assign w_mem_addr  = i_cmd.clr_step ? r_clr_addr
                       : {r_ridx[ehcw_pkg::R_IDX_W-1:0], w_row[ehcw_pkg::Y_W-1:0], r_x};

    ehcw_ram #(
        .WIDTH (ehcw_pkg::VOTE_W),
        .DEPTH (ehcw_pkg::MEM_DEPTH)
    ) u_vote_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (i_cmd.cell_read),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // Event queue: push at the tail, read at the head.
    assign w_q_addr = i_cmd.push ? (r_q_head + r_q_count[ehcw_pkg::Q_AW-1:0]) : r_q_head;

    ehcw_ram #(
        .WIDTH (ehcw_pkg::EV_W),
        .DEPTH (ehcw_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_re    (i_cmd.queue_rd),
        .i_addr  (w_q_addr),
        .i_wdata ({r_ev_y, r_ev_x}),
        .o_rdata (w_q_rdata)
    );

    // Status toward the controller.
    always_comb begin
        o_sts.clr_done  = (r_clr_addr == ehcw_pkg::MEM_AW'(ehcw_pkg::MEM_DEPTH - 1));
        o_sts.need_pop  = (r_q_count > ehcw_pkg::CNT_W'(r_window_length))
                       || (r_q_count >= ehcw_pkg::CNT_W'(ehcw_pkg::QUEUE_DEPTH));
        o_sts.rad_done  = (r_ridx == (ehcw_pkg::R_IDX_W + 1)'(ehcw_pkg::NUM_RADII));
        o_sts.col_done  = (r_x >= r_xe);
        o_sts.sqrt_last = (r_bit == '0);
        o_sts.row_ok    = w_row_ok;
        o_sts.cell_last = w_cell_last;
        o_sts.add_pass  = r_add;
        o_sts.out_full  = r_out_valid;
    end

    // Control registers: configuration, queue pointers, sweep, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_radius    <= ehcw_pkg::MINR_W'(ehcw_pkg::MINR_RST);
            r_window_length <= ehcw_pkg::WLEN_W'(ehcw_pkg::WLEN_RST);
            r_clr_addr      <= '0;
            r_q_head        <= '0;
            r_q_count       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ehcw_pkg::CFG_MIN_RADIUS:
                        r_min_radius <= i_cfg_data[ehcw_pkg::MINR_W-1:0];
                    ehcw_pkg::CFG_WINDOW_LENGTH:
                        r_window_length <= i_cfg_data[ehcw_pkg::WLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.push) r_q_count <= r_q_count + 1'b1;
            if (i_cmd.pop_done) begin
                r_q_head  <= r_q_head + 1'b1;
                r_q_count <= r_q_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pass cursor, geometry and square root iteration.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_event) begin
            r_ev_x <= i_event_x;
            r_ev_y <= i_event_y;
        end
        if (i_cmd.push) begin
            r_cx   <= r_ev_x;
            r_cy   <= r_ev_y;
            r_add  <= 1'b1;
            r_ridx <= '0;
        end
        if (i_cmd.pop_load) begin
            r_cx   <= w_q_rdata[ehcw_pkg::X_W-1:0];
            r_cy   <= w_q_rdata[ehcw_pkg::EV_W-1:ehcw_pkg::X_W];
            r_add  <= 1'b0;
            r_ridx <= '0;
        end
        if (i_cmd.rad_init) begin
            r_rad    <= w_rad;
            r_rad_sq <= w_rad * w_rad;
            r_x      <= w_lo[ehcw_pkg::RAD_W+1] ? '0 : w_lo[ehcw_pkg::X_W-1:0];
            r_xe     <= (w_hi > (ehcw_pkg::RAD_W + 2)'(ehcw_pkg::IMG_W - 1))
                      ? ehcw_pkg::X_W'(ehcw_pkg::IMG_W - 1) : w_hi[ehcw_pkg::X_W-1:0];
        end
        if (i_cmd.rad_next) r_ridx <= r_ridx + 1'b1;
        if (i_cmd.col_init) begin
            r_sq    <= r_rad_sq - ehcw_pkg::SQ_W'(w_dx_sq);
            r_root  <= '0;
            r_bit   <= ehcw_pkg::BIT_W'(ehcw_pkg::RAD_W - 1);
            r_s     <= 2'd0;
            r_minus <= 1'b0;
        end
        if (i_cmd.sqrt_step) begin
            if (w_trial_sq <= r_sq) r_root <= w_trial;
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.cell_next) begin
            if (w_cell_last) begin
                r_x <= r_x + 1'b1;
            end else begin
                r_minus <= !r_minus;
                if (r_minus) r_s <= r_s + 1'b1;
            end
        end
    end

    // Best incremented cell; a later cell wins only with strictly more votes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_best_votes <= '0;
            r_best_x     <= '0;
            r_best_y     <= '0;
            r_best_rad   <= '0;
        end else if (i_cmd.cell_write && r_add && (w_new > r_best_votes)) begin
            r_best_votes <= w_new;
            r_best_x     <= r_x;
            r_best_y     <= w_row[ehcw_pkg::Y_W-1:0];
            r_best_rad   <= (r_rad > ehcw_pkg::RAD_W'(ehcw_pkg::RADO_MAX))
                          ? ehcw_pkg::RADO_W'(ehcw_pkg::RADO_MAX)
                          : r_rad[ehcw_pkg::RADO_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_found <= (r_best_votes != '0);
            r_o_cx    <= r_best_x;
            r_o_cy    <= r_best_y;
            r_o_rad   <= r_best_rad;
            r_o_votes <= r_best_votes;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_o_found;
    assign o_res.center_x = r_o_cx;
    assign o_res.center_y = r_o_cy;
    assign o_res.radius   = r_o_rad;
    assign o_res.votes    = r_o_votes;

    // Checks on queue occupancy, memory access order and result hand-off.
    `EHCW_ASSERT_ALWAYS(a_queue_bound, r_q_count <= ehcw_pkg::CNT_W'(ehcw_pkg::QUEUE_DEPTH), "queue count over depth")
    `EHCW_ASSERT_IMPLY(a_write_after_read, i_cmd.cell_write, $past(i_cmd.cell_read), "cell write without read")
    `EHCW_ASSERT_IMPLY(a_no_overwrite, i_cmd.out_load, !r_out_valid, "result overwritten before taken")
    `EHCW_ASSERT_IMPLY(a_pop_nonempty, i_cmd.pop_done, r_q_count != '0, "pop from empty queue")

endmodule

// ===== rtl/core/event_hough_circle_window.sv =====
// Top level of the sliding-window circle Hough transform over pixel events.
// Depends on ehcw_pkg, ehcw_in_if, ehcw_out_if, ehcw_ctrl and ehcw_datapath.
//
//   Channel   Direction  Payload                                   Handshake
//   i_evt     in         event_x, event_y                          valid/ready
//   o_res     out        found, center_x, center_y, radius, votes  valid/ready
//   i_cfg_*   in         register index, data                      write enable
//
// After reset the vote memory is swept to zero, one cell per cycle, over all 393216
// cells; no event is accepted during the sweep (configuration writes are taken).
// One event is processed at a time. Each vote or withdrawal pass steps through the
// radii; per radius it walks the columns, and per column it sets up and runs the
// square root, then visits each of the six candidate rows, with a read-modify-write
// on the single vote memory port for each in-range row.
// A result waits in the output register while the next event is accepted;
// a stalled output holds the block only at the end of the next vote pass.
module event_hough_circle_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ehcw_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [ehcw_pkg::CFG_DW-1:0]   i_cfg_data,
    ehcw_in_if.sink                       i_evt,
    ehcw_out_if.source                    o_res
);

    ehcw_pkg::t_dp_cmd w_cmd;
    ehcw_pkg::t_dp_sts w_sts;

    // Sequencer.
    ehcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (i_evt.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    ehcw_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_event_x  (i_evt.event_x),
        .i_event_y  (i_evt.event_y),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

endmodule
